>>> hw/rtl/gnss_binary_frame_parser_macros.svh
// Assertion macros shared by the frame parser modules.
`ifndef GNSS_BINARY_FRAME_PARSER_MACROS_SVH
`define GNSS_BINARY_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge, switched off while reset is applied.
`define GBFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Property checked on every rising edge, including during reset.
`define GBFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GBFP_ASSERT(lbl, clk, rstn, prop, msg)
`define GBFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/gbfp_pkg.sv
`default_nettype none

package gbfp_pkg;

    // Frame delimiters.
    localparam logic [7:0] SYNC_A = 8'hA0;
    localparam logic [7:0] SYNC_B = 8'hA1;
    localparam logic [7:0] END_A  = 8'h0D;
    localparam logic [7:0] END_B  = 8'h0A;

    // Navigation message layout.
    localparam logic [15:0] NAV_LEN   = 16'd59;
    localparam int          CAP_DEPTH = 25;
    localparam int          CAP_IDX_W = $clog2(CAP_DEPTH);

    // Register reset values.
    localparam logic [15:0] MAX_LEN_RESET = 16'd200;
    localparam logic [7:0]  NAV_ID_RESET  = 8'hA8;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_NAV_ID  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_NAV_OK    = 3'd0;
    localparam logic [2:0] ST_OTHER_OK  = 3'd1;
    localparam logic [2:0] ST_START1    = 3'd2;
    localparam logic [2:0] ST_START2    = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;
    localparam logic [2:0] ST_TRAILER1  = 3'd5;
    localparam logic [2:0] ST_TRAILER2  = 3'd6;
    localparam logic [2:0] ST_CHECKSUM  = 3'd7;

    typedef struct packed {
        logic [15:0] max_payload_length;
        logic [7:0]  nav_message_id;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         message_id;
        logic [15:0]        frame_length;
        logic [7:0]         fix_mode;
        logic [7:0]         satellite_count;
        logic [15:0]        week_number;
        logic [31:0]        time_of_week;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [31:0]        altitude_sea_level;
        logic [31:0]        frame_timestamp;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/gbfp_in_if.sv
`default_nettype none

interface gbfp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] tick_ms;

    modport source (output valid, output rx_byte, output tick_ms, input ready);
    modport sink (input valid, input rx_byte, input tick_ms, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gbfp_out_if.sv
`default_nettype none

interface gbfp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         message_id;
    logic [15:0]        frame_length;
    logic [7:0]         fix_mode;
    logic [7:0]         satellite_count;
    logic [15:0]        week_number;
    logic [31:0]        time_of_week;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [31:0]        altitude_sea_level;
    logic [31:0]        frame_timestamp;

    modport source (
        output valid, output status, output message_id, output frame_length,
        output fix_mode, output satellite_count, output week_number,
        output time_of_week, output latitude, output longitude,
        output altitude_sea_level, output frame_timestamp, input ready
    );
    modport sink (
        input valid, input status, input message_id, input frame_length,
        input fix_mode, input satellite_count, input week_number,
        input time_of_week, input latitude, input longitude,
        input altitude_sea_level, input frame_timestamp, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/gnss_binary_frame_parser.sv
// GNSS binary frame parser.
//
// Received serial bytes enter on the rx channel, one word per byte, each
// with the millisecond tick at which it arrived. The parser hunts for frames
// of the form A0 A1, big-endian 16-bit length, payload, XOR checksum, 0D 0A,
// and sends one word on the frame channel for every error and for every
// completed frame. Navigation frames are decoded into their fields.
// The two configuration registers (maximum payload length and navigation
// message id) are written over the APB port. The user is to write them only
// while the parser is idle; the block itself does not enforce this.
//
// A byte from rx waits in the input register until the output register is
// free or being emptied; the deframer then processes it and any result
// goes to the output register. Throughput is one byte per cycle while the
// receiver does not stall, set by the single deframer stage, which updates
// its state once per byte. While the receiver stalls, the output register
// holds its word and the input register takes one further byte before
// rx.ready falls. Reset empties both registers, restores the register
// defaults and returns the deframer to hunting for the first start byte.

`default_nettype none

`include "gnss_binary_frame_parser_macros.svh"

module gnss_binary_frame_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gbfp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gbfp_pkg::PDATA_W-1:0]  pwdata,
    output logic      [gbfp_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    gbfp_in_if.sink                            rx,
    gbfp_out_if.source                         frame
);

    gbfp_pkg::cfg_t    cfg;
    gbfp_pkg::result_t res;
    gbfp_pkg::result_t out_reg;
    logic              res_valid;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [31:0]       in_tick_reg;
    logic              out_valid_reg;
    logic              fire;

    gbfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A held byte is processed whenever the output register is free or
    // being emptied in the same cycle.
    assign fire     = in_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !in_valid_reg || fire;

    gbfp_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .tick_ms   (in_tick_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= res_valid;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
            in_tick_reg <= rx.tick_ms;
        end
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign frame.valid              = out_valid_reg;
    assign frame.status             = out_reg.status;
    assign frame.message_id         = out_reg.message_id;
    assign frame.frame_length       = out_reg.frame_length;
    assign frame.fix_mode           = out_reg.fix_mode;
    assign frame.satellite_count    = out_reg.satellite_count;
    assign frame.week_number        = out_reg.week_number;
    assign frame.time_of_week       = out_reg.time_of_week;
    assign frame.latitude           = out_reg.latitude;
    assign frame.longitude          = out_reg.longitude;
    assign frame.altitude_sea_level = out_reg.altitude_sea_level;
    assign frame.frame_timestamp    = out_reg.frame_timestamp;

    `GBFP_ASSERT(a_input_held, clk, rst_n,
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg)),
        "held input byte lost while the output register was full")

endmodule

`default_nettype wire

>>> hw/rtl/gbfp_cfg_regs.sv
`default_nettype none

module gbfp_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gbfp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [gbfp_pkg::PDATA_W-1:0]  pwdata,
    output logic      [gbfp_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output gbfp_pkg::cfg_t                     cfg
);

    gbfp_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic           reg_sel;

    // Registers sit on 4-byte boundaries, so the word index is the top address bit.
    assign reg_sel = paddr[gbfp_pkg::PADDR_W-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_length <= gbfp_pkg::MAX_LEN_RESET;
            cfg_reg.nav_message_id     <= gbfp_pkg::NAV_ID_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                gbfp_pkg::REG_MAX_LEN: cfg_reg.max_payload_length <= pwdata[15:0];
                gbfp_pkg::REG_NAV_ID:  cfg_reg.nav_message_id     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            gbfp_pkg::REG_MAX_LEN: prdata = {16'd0, cfg_reg.max_payload_length};
            gbfp_pkg::REG_NAV_ID:  prdata = {24'd0, cfg_reg.nav_message_id};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbfp_deframer.sv
`default_nettype none

`include "gnss_binary_frame_parser_macros.svh"

module gbfp_deframer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [31:0]     tick_ms,
    input  wire gbfp_pkg::cfg_t  cfg,
    output logic                 res_valid,
    output gbfp_pkg::result_t    res
);

    typedef enum logic [2:0] {
        PH_START1,
        PH_START2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECKSUM,
        PH_TRAIL1,
        PH_TRAIL2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [7:0]  running_checksum_reg, running_checksum_next;
    logic [7:0]  received_checksum_reg, received_checksum_next;
    logic [7:0]  first_trailer_reg, first_trailer_next;
    logic [31:0] start_timestamp_reg, start_timestamp_next;
    logic [7:0]  capture_reg [gbfp_pkg::CAP_DEPTH];

    logic [15:0] len_field;
    logic [15:0] index_inc;
    logic        cap_wr;
    logic        emit;

    assign len_field = {length_high_reg, rx_byte};
    assign index_inc = byte_index_reg + 16'd1;
    assign cap_wr    = fire && (phase_reg == PH_PAYLOAD)
                       && (byte_index_reg < 16'(gbfp_pkg::CAP_DEPTH));
    assign res_valid = fire && emit;

    always_comb
    begin
        phase_next             = phase_reg;
        length_high_next       = length_high_reg;
        payload_length_next    = payload_length_reg;
        byte_index_next        = byte_index_reg;
        running_checksum_next  = running_checksum_reg;
        received_checksum_next = received_checksum_reg;
        first_trailer_next     = first_trailer_reg;
        start_timestamp_next   = start_timestamp_reg;
        emit                   = 1'b0;
        res                    = '0;
        res.frame_timestamp    = start_timestamp_reg;

        case (phase_reg)
            PH_START1:
            begin
                if (rx_byte == gbfp_pkg::SYNC_A)
                begin
                    start_timestamp_next = tick_ms;
                    phase_next           = PH_START2;
                end
                else
                begin
                    emit                = 1'b1;
                    res.status          = gbfp_pkg::ST_START1;
                    res.frame_timestamp = tick_ms;
                end
            end
            PH_START2:
            begin
                if (rx_byte == gbfp_pkg::SYNC_B)
                begin
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    phase_next = PH_START1;
                    emit       = 1'b1;
                    res.status = gbfp_pkg::ST_START2;
                end
            end
            PH_LEN_HI:
            begin
                length_high_next = rx_byte;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                payload_length_next = len_field;
                if (len_field > cfg.max_payload_length)
                begin
                    phase_next       = PH_START1;
                    emit             = 1'b1;
                    res.status       = gbfp_pkg::ST_LENGTH;
                    res.frame_length = len_field;
                end
                else
                begin
                    running_checksum_next = '0;
                    byte_index_next       = '0;
                    phase_next = (len_field == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                running_checksum_next = running_checksum_reg ^ rx_byte;
                byte_index_next       = index_inc;
                if (index_inc >= payload_length_reg)
                begin
                    phase_next = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM:
            begin
                received_checksum_next = rx_byte;
                phase_next             = PH_TRAIL1;
            end
            PH_TRAIL1:
            begin
                first_trailer_next = rx_byte;
                phase_next         = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                phase_next       = PH_START1;
                emit             = 1'b1;
                res.frame_length = payload_length_reg;
                if (first_trailer_reg != gbfp_pkg::END_A)
                begin
                    res.status = gbfp_pkg::ST_TRAILER1;
                end
                else if (rx_byte != gbfp_pkg::END_B)
                begin
                    res.status = gbfp_pkg::ST_TRAILER2;
                end
                else if (running_checksum_reg != received_checksum_reg)
                begin
                    res.status = gbfp_pkg::ST_CHECKSUM;
                end
                else if (payload_length_reg == 16'd0)
                begin
                    res.status = gbfp_pkg::ST_OTHER_OK;
                end
                else if ((capture_reg[0] == cfg.nav_message_id)
                         && (payload_length_reg == gbfp_pkg::NAV_LEN))
                begin
                    res.status             = gbfp_pkg::ST_NAV_OK;
                    res.message_id         = capture_reg[0];
                    res.fix_mode           = capture_reg[1];
                    res.satellite_count    = capture_reg[2];
                    res.week_number        = {capture_reg[3], capture_reg[4]};
                    res.time_of_week       = {capture_reg[5], capture_reg[6],
                                              capture_reg[7], capture_reg[8]};
                    res.latitude           = {capture_reg[9], capture_reg[10],
                                              capture_reg[11], capture_reg[12]};
                    res.longitude          = {capture_reg[13], capture_reg[14],
                                              capture_reg[15], capture_reg[16]};
                    res.altitude_sea_level = {capture_reg[21], capture_reg[22],
                                              capture_reg[23], capture_reg[24]};
                end
                else
                begin
                    res.status     = gbfp_pkg::ST_OTHER_OK;
                    res.message_id = capture_reg[0];
                end
            end
            default:
            begin
                phase_next = PH_START1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_START1;
            length_high_reg       <= '0;
            payload_length_reg    <= '0;
            byte_index_reg        <= '0;
            running_checksum_reg  <= '0;
            received_checksum_reg <= '0;
            first_trailer_reg     <= '0;
            start_timestamp_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg             <= phase_next;
            length_high_reg       <= length_high_next;
            payload_length_reg    <= payload_length_next;
            byte_index_reg        <= byte_index_next;
            running_checksum_reg  <= running_checksum_next;
            received_checksum_reg <= received_checksum_next;
            first_trailer_reg     <= first_trailer_next;
            start_timestamp_reg   <= start_timestamp_next;
        end
    end

    // The capture store takes the first 25 payload bytes; later entries may be stale.
    always_ff @(posedge clk)
    begin
        if (cap_wr)
        begin
            capture_reg[byte_index_reg[gbfp_pkg::CAP_IDX_W-1:0]] <= rx_byte;
        end
    end

    `GBFP_ASSERT(a_index_in_range, clk, rst_n,
        (phase_reg == PH_PAYLOAD) |-> (byte_index_reg < payload_length_reg),
        "payload index has run past the frame length")

    `GBFP_ASSERT(a_emit_phase, clk, rst_n,
        res_valid |-> ((phase_reg == PH_START1) || (phase_reg == PH_START2)
                       || (phase_reg == PH_LEN_LO) || (phase_reg == PH_TRAIL2)),
        "result raised in a phase that never completes a word")

    `GBFP_ASSERT(a_nav_length, clk, rst_n,
        (res_valid && (res.status == gbfp_pkg::ST_NAV_OK))
            |-> (payload_length_reg == gbfp_pkg::NAV_LEN),
        "navigation result decoded from a frame of the wrong length")

endmodule

`default_nettype wire
